@@ sv/wpp_pkg.sv @@
// wpp_pkg: shared types and constants of the wav pcm16 stream parser
// result item layout, kind and error codes, riff tag words
// no dependencies
package wpp_pkg;

   localparam logic [1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [1:0] KIND_FORMAT   = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;
   localparam logic [1:0] KIND_FINISHED = 2'd3;

   localparam logic [2:0] ERR_NOT_RIFF      = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE      = 3'd1;
   localparam logic [2:0] ERR_FMT_SIZE      = 3'd2;
   localparam logic [2:0] ERR_NOT_PCM       = 3'd3;
   localparam logic [2:0] ERR_BIT_DEPTH     = 3'd4;
   localparam logic [2:0] ERR_CHUNK_MISSING = 3'd5;
   localparam logic [2:0] ERR_TRUNCATED     = 3'd6;
   localparam logic [2:0] ERR_ZERO_CHANNELS = 3'd7;

   // tags as they read after four little-endian bytes
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
   localparam logic [15:0] AUDIO_PCM      = 16'd1;
   localparam logic [15:0] BITS_PER_SMP   = 16'd16;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        channel;
      logic signed [15:0] sample;
      logic [15:0]        channel_count;
      logic [31:0]        rate_hz;
      logic [2:0]         error_code;
      logic               last;
   } wpp_result_type;

endpackage

@@ sv/wpp_req_if.sv @@
// wpp_req_if: byte input channel of the wav pcm16 stream parser
// valid/ready handshake with the raw file byte and end of file flag
// no dependencies
interface wpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_file;

   modport source (output valid, output byte_in, output end_of_file, input ready);
   modport sink   (input valid, input byte_in, input end_of_file, output ready);
endinterface

@@ sv/wpp_rsp_if.sv @@
// wpp_rsp_if: result channel of the wav pcm16 stream parser
// valid/ready handshake with one result item
// no dependencies
interface wpp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [15:0]        channel;
   logic signed [15:0] sample;
   logic [15:0]        channel_count;
   logic [31:0]        rate_hz;
   logic [2:0]         error_code;
   logic               last;

   modport source (output valid, output kind, output channel, output sample,
                   output channel_count, output rate_hz, output error_code,
                   output last, input ready);
   modport sink   (input valid, input kind, input channel, input sample,
                   input channel_count, input rate_hz, input error_code,
                   input last, output ready);
endinterface

@@ sv/wpp_parser.sv @@
// wpp_parser: riff/wave parse state and per-byte step logic
// gives up to two result items for each stepped byte
// depends on wpp_pkg
module wpp_parser import wpp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_valid,
   input  logic [7:0]     byte_in,
   input  logic           end_of_file,
   output logic [1:0]     result_count,
   output wpp_result_type result_out [2]
);

   typedef enum logic [3:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FSIZE_SKIP, PH_FSIZE, PH_FSKIP,
      PH_FMT, PH_DID, PH_DSIZE_SKIP, PH_DSIZE, PH_DSKIP, PH_DATA, PH_HALT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] chunk_ff, chunk_in;
   logic [31:0] raw_ff, raw_in;
   logic [15:0] ch_total_ff, ch_total_in;
   logic [15:0] ch_idx_ff, ch_idx_in;
   logic [7:0]  low_ff, low_in;

   logic [31:0] asm_shift;
   logic [15:0] word_val;
   logic        take_done;
   logic [4:0]  pos_step;
   logic [31:0] frame_bytes;
   logic [16:0] idx_next;
   logic        frame_end;
   logic [31:0] raw_dec;

   logic           prim_v, extra_v, searching;
   wpp_result_type prim, extra;

   function automatic wpp_result_type make_result(
      input logic [1:0]  kind,
      input logic [15:0] channel,
      input logic [15:0] sample,
      input logic [15:0] channel_count,
      input logic [31:0] rate_hz,
      input logic [2:0]  error_code
   );
      wpp_result_type r;
      r.kind          = kind;
      r.channel       = channel;
      r.sample        = signed'(sample);
      r.channel_count = channel_count;
      r.rate_hz       = rate_hz;
      r.error_code    = error_code;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic wpp_result_type error_result(input logic [2:0] code);
      return make_result(KIND_ERROR, 16'd0, 16'd0, 16'd0, 32'd0, code);
   endfunction

   assign asm_shift   = {byte_in, asm_ff[31:8]};
   assign word_val    = {byte_in, low_ff};
   assign take_done   = (pos_ff >= 5'd3);
   assign pos_step    = take_done ? 5'd0 : pos_ff + 5'd1;
   assign frame_bytes = {15'd0, ch_total_ff, 1'b0};
   assign idx_next    = {1'b0, ch_idx_ff} + 17'd1;
   assign frame_end   = (idx_next >= {1'b0, ch_total_ff});
   assign raw_dec     = raw_ff - 32'd1;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      asm_in      = asm_ff;
      chunk_in    = chunk_ff;
      raw_in      = raw_ff;
      ch_total_in = ch_total_ff;
      ch_idx_in   = ch_idx_ff;
      low_in      = low_ff;
      prim_v      = 1'b0;
      prim        = '0;
      extra_v     = 1'b0;
      extra       = '0;
      searching   = 1'b0;

      unique case (phase_ff)
         PH_RIFF: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) begin
               if (asm_shift != TAG_RIFF) begin
                  phase_in = PH_HALT;
                  prim_v   = 1'b1;
                  prim     = error_result(ERR_NOT_RIFF);
               end else begin
                  phase_in = PH_RSIZE;
               end
            end
         end
         PH_RSIZE: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) phase_in = PH_WAVE;
         end
         PH_WAVE: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) begin
               if (asm_shift != TAG_WAVE) begin
                  phase_in = PH_HALT;
                  prim_v   = 1'b1;
                  prim     = error_result(ERR_NOT_WAVE);
               end else begin
                  phase_in = PH_FID;
               end
            end
         end
         PH_FID: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) phase_in = (asm_shift == TAG_FMT) ? PH_FSIZE : PH_FSIZE_SKIP;
         end
         PH_FSIZE_SKIP: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) begin
               chunk_in = asm_shift;
               phase_in = (asm_shift == 32'd0) ? PH_FID : PH_FSKIP;
            end
         end
         PH_FSIZE: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) begin
               if (asm_shift != FMT_CHUNK_SIZE) begin
                  phase_in = PH_HALT;
                  prim_v   = 1'b1;
                  prim     = error_result(ERR_FMT_SIZE);
               end else begin
                  phase_in = PH_FMT;
               end
            end
         end
         PH_FSKIP: begin
            chunk_in = chunk_ff - 32'd1;
            if (chunk_ff == 32'd1) phase_in = PH_FID;
         end
         PH_FMT: begin
            pos_in = pos_ff + 5'd1;
            case (pos_ff) inside
               5'd0, 5'd2, 5'd14: low_in = byte_in;
               5'd1: begin
                  if (word_val != AUDIO_PCM) begin
                     phase_in = PH_HALT;
                     prim_v   = 1'b1;
                     prim     = error_result(ERR_NOT_PCM);
                  end
               end
               5'd3: ch_total_in = word_val;
               [5'd4:5'd7]: asm_in = asm_shift;
               5'd15: begin
                  prim_v = 1'b1;
                  if (word_val != BITS_PER_SMP) begin
                     phase_in = PH_HALT;
                     prim     = error_result(ERR_BIT_DEPTH);
                  end else begin
                     prim     = make_result(KIND_FORMAT, 16'd0, 16'd0, ch_total_ff,
                                            asm_ff, 3'd0);
                     phase_in = PH_DID;
                     pos_in   = 5'd0;
                  end
               end
               default: ;
            endcase
         end
         PH_DID: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) phase_in = (asm_shift == TAG_DATA) ? PH_DSIZE : PH_DSIZE_SKIP;
         end
         PH_DSIZE_SKIP: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) begin
               chunk_in = asm_shift;
               phase_in = (asm_shift == 32'd0) ? PH_DID : PH_DSKIP;
            end
         end
         PH_DSIZE: begin
            asm_in = asm_shift;
            pos_in = pos_step;
            if (take_done) begin
               if (ch_total_ff == 16'd0) begin
                  phase_in = PH_HALT;
                  prim_v   = 1'b1;
                  prim     = error_result(ERR_ZERO_CHANNELS);
               end else begin
                  // raw size counts down; frames end when less than a frame remains
                  raw_in    = asm_shift;
                  ch_idx_in = 16'd0;
                  pos_in    = 5'd0;
                  if (asm_shift < frame_bytes) begin
                     phase_in = PH_HALT;
                     prim_v   = 1'b1;
                     prim     = make_result(KIND_FINISHED, 16'd0, 16'd0, 16'd0, 32'd0,
                                            3'd0);
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end
         PH_DSKIP: begin
            chunk_in = chunk_ff - 32'd1;
            if (chunk_ff == 32'd1) phase_in = PH_DID;
         end
         PH_DATA: begin
            raw_in = raw_dec;
            if (!pos_ff[0]) begin
               low_in = byte_in;
               pos_in = 5'd1;
            end else begin
               pos_in    = 5'd0;
               prim_v    = 1'b1;
               prim      = make_result(KIND_SAMPLE, ch_idx_ff, word_val, 16'd0, 32'd0,
                                       3'd0);
               ch_idx_in = frame_end ? 16'd0 : idx_next[15:0];
               // no whole frame left after this one
               if (frame_end && (raw_dec < frame_bytes)) begin
                  phase_in = PH_HALT;
                  extra_v  = 1'b1;
                  extra    = make_result(KIND_FINISHED, 16'd0, 16'd0, 16'd0, 32'd0,
                                         3'd0);
               end
            end
         end
         PH_HALT: ;
         default: phase_in = PH_HALT;
      endcase

      if (end_of_file) begin
         if (phase_in != PH_HALT) begin
            searching = (phase_in >= PH_FID && phase_in <= PH_FSKIP) ||
                        (phase_in >= PH_DID && phase_in <= PH_DSKIP);
            extra_v   = 1'b1;
            extra     = error_result(searching ? ERR_CHUNK_MISSING : ERR_TRUNCATED);
         end
         phase_in    = PH_RIFF;
         pos_in      = 5'd0;
         asm_in      = 32'd0;
         chunk_in    = 32'd0;
         raw_in      = 32'd0;
         ch_total_in = 16'd0;
         ch_idx_in   = 16'd0;
         low_in      = 8'd0;
      end
   end

   always_comb begin
      result_count  = {1'b0, prim_v} + {1'b0, extra_v};
      result_out[0] = prim_v ? prim : extra;
      result_out[1] = extra;
      if (prim_v && extra_v) begin
         result_out[1].last = 1'b1;
      end else begin
         result_out[0].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         pos_ff      <= 5'd0;
         asm_ff      <= 32'd0;
         chunk_ff    <= 32'd0;
         raw_ff      <= 32'd0;
         ch_total_ff <= 16'd0;
         ch_idx_ff   <= 16'd0;
         low_ff      <= 8'd0;
      end else if (step_valid) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         asm_ff      <= asm_in;
         chunk_ff    <= chunk_in;
         raw_ff      <= raw_in;
         ch_total_ff <= ch_total_in;
         ch_idx_ff   <= ch_idx_in;
         low_ff      <= low_in;
      end
   end

endmodule

@@ sv/wpp_result_fifo.sv @@
// wpp_result_fifo: four-entry queue of result items
// takes up to two items per cycle, gives one
// depends on wpp_pkg
module wpp_result_fifo import wpp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     push_count,
   input  wpp_result_type push_data [2],
   input  logic           pop,
   output wpp_result_type head,
   output logic           head_valid,
   output logic [2:0]     fill
);

   wpp_result_type entry_ff [4];
   logic [1:0]     wr_ptr_ff, wr_ptr_in;
   logic [1:0]     rd_ptr_ff, rd_ptr_in;
   logic [2:0]     count_ff, count_in;
   logic [1:0]     wr_next;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 3'd0);
   assign fill       = count_ff;
   assign wr_next    = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) entry_ff[wr_ptr_ff] <= push_data[0];
      if (push_count == 2'd2) entry_ff[wr_next] <= push_data[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/wav_pcm16_stream_parser_top.sv @@
// wav_pcm16_stream_parser_top: byte-wide riff/wave pcm16 parser
// a byte passes the input register and then the result queue before its first result reaches rsp
// throughput: one byte per cycle while the result queue has room; a byte with two results queues both for rsp
// a byte is stepped from the input register once the result queue has room for two
// reset (synchronous) and the end of file byte both return the parser to the riff tag
// depends on wpp_pkg, wpp_req_if, wpp_rsp_if, wpp_parser, wpp_result_fifo
module wav_pcm16_stream_parser_top import wpp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wpp_req_if.sink   req_chan,
   wpp_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       advance;
   logic       req_take;

   logic [1:0]     result_count;
   logic [1:0]     push_count;
   wpp_result_type result_out [2];
   wpp_result_type head;
   logic           head_valid;
   logic [2:0]     fill;
   logic           pop;

   assign advance        = in_valid_ff && (fill <= 3'd2);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign push_count     = advance ? result_count : 2'd0;
   assign pop            = head_valid && rsp_chan.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.byte_in;
         in_eof_ff  <= req_chan.end_of_file;
      end
   end

   wpp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (advance),
      .byte_in      (in_byte_ff),
      .end_of_file  (in_eof_ff),
      .result_count (result_count),
      .result_out   (result_out)
   );

   wpp_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (result_out),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .fill       (fill)
   );

   assign rsp_chan.valid         = head_valid;
   assign rsp_chan.kind          = head.kind;
   assign rsp_chan.channel       = head.channel;
   assign rsp_chan.sample        = head.sample;
   assign rsp_chan.channel_count = head.channel_count;
   assign rsp_chan.rate_hz       = head.rate_hz;
   assign rsp_chan.error_code    = head.error_code;
   assign rsp_chan.last          = head.last;

endmodule

@@ tb/testbench.sv @@
// testbench for wav_pcm16_stream_parser_top: feeds whole and broken wav files byte by byte
// and checks every result item against a parser model kept in this file
// depends on wpp_pkg, wpp_req_if, wpp_rsp_if and the parser rtl
module testbench import wpp_pkg::*;;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam int unsigned BYTE_TARGET = 1500;

   typedef enum logic [3:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FSIZE_SKIP, PH_FSIZE, PH_FSKIP, PH_FMT,
      PH_DID, PH_DSIZE_SKIP, PH_DSIZE, PH_DSKIP, PH_DATA, PH_HALT
   } parse_phase_type;

   typedef enum {
      SC_RANDOM, SC_ZERO_CHANNELS, SC_EMPTY_DATA, SC_TRAILING, SC_TRUNCATED,
      SC_BAD_PCM, SC_BAD_DEPTH, SC_BAD_FMT_SIZE
   } file_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       eof;
      bit         hold;
   } file_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wpp_req_if req_if ();
   wpp_rsp_if rsp_if ();

   wav_pcm16_stream_parser_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state
   parse_phase_type ph;
   logic [4:0]      pos;
   logic [31:0]     word_acc, chunk_left, data_left;
   logic [15:0]     n_chan, chan_idx;
   logic [7:0]      lo_byte;

   wpp_result_type step_out[$];
   wpp_result_type expected_results[$];
   file_byte_type  pending_bytes[$];
   logic [7:0]     file_bytes[$];

   file_byte_type next_byte;
   bit            byte_taken;
   int unsigned   send_gap, stall_left, calm_left, mismatch_count;

   function automatic void clear_parser();
      ph = PH_RIFF;
      pos = '0;
      word_acc = '0;
      chunk_left = '0;
      data_left = '0;
      n_chan = '0;
      chan_idx = '0;
      lo_byte = '0;
   endfunction

   function automatic void emit(logic [1:0] kind, logic [15:0] ch, logic [15:0] smp,
                                logic [15:0] cnt, logic [31:0] rate, logic [2:0] err);
      wpp_result_type r;
      r.kind = kind;
      r.channel = ch;
      r.sample = smp;
      r.channel_count = cnt;
      r.rate_hz = rate;
      r.error_code = err;
      r.last = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void halt_with(logic [2:0] code);
      ph = PH_HALT;
      emit(KIND_ERROR, '0, '0, '0, '0, code);
   endfunction

   // little-endian word assembly, true on the fourth byte
   function automatic bit shift_in(logic [7:0] b);
      word_acc = {b, word_acc[31:8]};
      if (pos >= 5'd3) begin
         pos = '0;
         return 1'b1;
      end
      pos++;
      return 1'b0;
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic eof);
      logic [4:0]  p;
      logic [15:0] w;
      logic [31:0] frame;
      step_out.delete();
      case (ph)
         PH_RIFF: begin
            if (shift_in(b)) begin
               if (word_acc != TAG_RIFF) halt_with(ERR_NOT_RIFF);
               else ph = PH_RSIZE;
            end
         end
         PH_RSIZE: begin
            if (shift_in(b)) ph = PH_WAVE;
         end
         PH_WAVE: begin
            if (shift_in(b)) begin
               if (word_acc != TAG_WAVE) halt_with(ERR_NOT_WAVE);
               else ph = PH_FID;
            end
         end
         PH_FID: begin
            if (shift_in(b)) ph = (word_acc == TAG_FMT) ? PH_FSIZE : PH_FSIZE_SKIP;
         end
         PH_FSIZE_SKIP: begin
            if (shift_in(b)) begin
               chunk_left = word_acc;
               ph = (chunk_left == 0) ? PH_FID : PH_FSKIP;
            end
         end
         PH_FSIZE: begin
            if (shift_in(b)) begin
               if (word_acc != FMT_CHUNK_SIZE) begin
                  halt_with(ERR_FMT_SIZE);
               end else begin
                  ph = PH_FMT;
                  pos = '0;
               end
            end
         end
         PH_FSKIP: begin
            chunk_left--;
            if (chunk_left == 0) ph = PH_FID;
         end
         PH_FMT: begin
            p = pos;
            w = {b, lo_byte};
            pos = p + 5'd1;
            if (p == 0 || p == 2 || p == 14) begin
               lo_byte = b;
            end else if (p == 1) begin
               if (w != AUDIO_PCM) halt_with(ERR_NOT_PCM);
            end else if (p == 3) begin
               n_chan = w;
            end else if (p >= 4 && p <= 7) begin
               word_acc = {b, word_acc[31:8]};
            end else if (p == 15) begin
               if (w != BITS_PER_SMP) begin
                  halt_with(ERR_BIT_DEPTH);
               end else begin
                  emit(KIND_FORMAT, '0, '0, n_chan, word_acc, ERR_NONE);
                  ph = PH_DID;
                  pos = '0;
               end
            end
         end
         PH_DID: begin
            if (shift_in(b)) ph = (word_acc == TAG_DATA) ? PH_DSIZE : PH_DSIZE_SKIP;
         end
         PH_DSIZE_SKIP: begin
            if (shift_in(b)) begin
               chunk_left = word_acc;
               ph = (chunk_left == 0) ? PH_DID : PH_DSKIP;
            end
         end
         PH_DSIZE: begin
            if (shift_in(b)) begin
               if (n_chan == 0) begin
                  halt_with(ERR_ZERO_CHANNELS);
               end else begin
                  frame = {15'd0, n_chan, 1'b0};
                  data_left = (word_acc / frame) * frame;
                  chan_idx = '0;
                  pos = '0;
                  if (data_left == 0) begin
                     ph = PH_HALT;
                     emit(KIND_FINISHED, '0, '0, '0, '0, ERR_NONE);
                  end else begin
                     ph = PH_DATA;
                  end
               end
            end
         end
         PH_DSKIP: begin
            chunk_left--;
            if (chunk_left == 0) ph = PH_DID;
         end
         PH_DATA: begin
            if (!pos[0]) begin
               lo_byte = b;
               pos = 5'd1;
            end else begin
               pos = '0;
               emit(KIND_SAMPLE, chan_idx, {b, lo_byte}, '0, '0, ERR_NONE);
               chan_idx++;
               if (chan_idx >= n_chan) chan_idx = '0;
            end
            data_left--;
            if (data_left == 0) begin
               ph = PH_HALT;
               emit(KIND_FINISHED, '0, '0, '0, '0, ERR_NONE);
            end
         end
         default: ph = PH_HALT;
      endcase
      if (eof) begin
         if (ph != PH_HALT) begin
            emit(KIND_ERROR, '0, '0, '0, '0,
                 (ph inside {[PH_FID:PH_FSKIP], [PH_DID:PH_DSKIP]}) ?
                 ERR_CHUNK_MISSING : ERR_TRUNCATED);
         end
         clear_parser();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) expected_results.insert(expected_results.size(), step_out[i]);
   endfunction

   function automatic string show_result(wpp_result_type r);
      return $sformatf("kind %0d ch %0d smp %0d cnt %0d rate %0d err %0d last %0d",
                       r.kind, r.channel, r.sample, r.channel_count, r.rate_hz,
                       r.error_code, r.last);
   endfunction

   task automatic check_result();
      wpp_result_type got, want;
      bit bad;
      got.kind = rsp_if.kind;
      got.channel = rsp_if.channel;
      got.sample = rsp_if.sample;
      got.channel_count = rsp_if.channel_count;
      got.rate_hz = rsp_if.rate_hz;
      got.error_code = rsp_if.error_code;
      got.last = rsp_if.last;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result: %s", show_result(got));
      end else begin
         want = expected_results.pop_front();
         bad = (got.kind !== want.kind) || (got.channel !== want.channel) ||
               (got.sample !== want.sample) || (got.channel_count !== want.channel_count) ||
               (got.rate_hz !== want.rate_hz) || (got.error_code !== want.error_code) ||
               (got.last !== want.last);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch: expected %s", show_result(want));
               $display("          actual   %s", show_result(got));
            end
         end
      end
   endtask

   // mostly short gaps, a few long ones, none during a calm stretch
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_left > 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic put_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++) file_bytes.insert(file_bytes.size(), v[8*i +: 8]);
   endtask

   task automatic put_random(int unsigned n);
      for (int unsigned i = 0; i < n; i++) file_bytes.insert(file_bytes.size(), rand_byte());
   endtask

   task automatic put_other_chunk(logic [31:0] alt_tag);
      logic [31:0] len;
      len = $urandom_range(0, 5);
      put_le(($urandom_range(0, 4) == 0) ? alt_tag : $urandom, 4);
      put_le(len, 4);
      put_random(len);
   endtask

   task automatic flush_file(bit hold);
      file_byte_type fb;
      foreach (file_bytes[i]) begin
         fb.data = file_bytes[i];
         fb.eof = (i == file_bytes.size() - 1);
         fb.hold = hold && (i == 0);
         pending_bytes.insert(pending_bytes.size(), fb);
      end
      file_bytes.delete();
   endtask

   task automatic build_wave_file(file_kind_type sc);
      int unsigned pick, nframes, body_len, extra, idx;
      logic [15:0] chans, fmt_code, depth;
      logic [31:0] fsize, dsize, frame, rate;
      if (sc == SC_RANDOM && $urandom_range(0, 99) < 6) begin
         put_random($urandom_range(1, 10));
         flush_file(1'b0);
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) chans = 16'd1;
      else if (pick < 65) chans = 16'd2;
      else if (pick < 80) chans = 16'($urandom_range(3, 6));
      else if (pick < 87) chans = 16'd0;
      else if (pick < 93) chans = 16'hFFFF;
      else chans = 16'($urandom_range(0, 65535));
      fmt_code = ($urandom_range(0, 99) < 94) ? AUDIO_PCM : 16'($urandom);
      depth = ($urandom_range(0, 99) < 94) ? BITS_PER_SMP : 16'($urandom);
      fsize = ($urandom_range(0, 99) < 95) ? FMT_CHUNK_SIZE : $urandom_range(0, 40);
      nframes = $urandom_range(0, 7);
      extra = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 6) : 0;
      if (sc != SC_RANDOM) begin
         fmt_code = AUDIO_PCM;
         depth = BITS_PER_SMP;
         fsize = FMT_CHUNK_SIZE;
         chans = 16'($urandom_range(1, 4));
         nframes = $urandom_range(1, 5);
      end
      case (sc)
         SC_ZERO_CHANNELS: chans = '0;
         SC_EMPTY_DATA:    nframes = 0;
         SC_TRAILING:      extra = $urandom_range(3, 10);
         SC_BAD_PCM:       fmt_code = AUDIO_PCM + 16'($urandom_range(1, 65535));
         SC_BAD_DEPTH:     depth = BITS_PER_SMP + 16'($urandom_range(1, 65535));
         SC_BAD_FMT_SIZE:  fsize = FMT_CHUNK_SIZE ^ (32'd1 << $urandom_range(0, 31));
         default: ;
      endcase
      frame = {15'd0, chans, 1'b0};
      if (chans >= 1 && chans <= 6) begin
         dsize = nframes * frame;
         if ($urandom_range(0, 3) == 0) dsize += $urandom_range(0, frame - 1);
      end else begin
         dsize = $urandom_range(0, 48);
      end
      if (sc == SC_EMPTY_DATA) dsize = $urandom_range(0, frame - 1);
      if (sc == SC_RANDOM && $urandom_range(0, 99) < 5) dsize = 32'hFFFF_FFFF;
      body_len = (dsize > 60) ? 60 : dsize;
      if (sc == SC_TRUNCATED) body_len = $urandom_range(0, body_len - 1);
      else if (sc == SC_RANDOM && $urandom_range(0, 99) < 10)
         body_len = $urandom_range(0, body_len);
      case ($urandom_range(0, 9))
         0: rate = '0;
         1: rate = 32'hFFFF_FFFF;
         default: rate = $urandom;
      endcase

      put_le(TAG_RIFF, 4);
      put_le($urandom, 4);
      put_le(TAG_WAVE, 4);
      // a data tag ahead of the format chunk is just another chunk to skip
      repeat (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2)) put_other_chunk(TAG_DATA);
      put_le(TAG_FMT, 4);
      put_le(fsize, 4);
      put_le(32'(fmt_code), 2);
      put_le(32'(chans), 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(32'(depth), 2);
      repeat (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2)) put_other_chunk(TAG_FMT);
      put_le(TAG_DATA, 4);
      put_le(dsize, 4);
      put_random(body_len);
      put_random(extra);

      if (sc == SC_RANDOM) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            idx = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[idx] ^= 8'd1 << $urandom_range(0, 7);
         end else if (pick < 15) begin
            idx = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > idx) void'(file_bytes.pop_back());
         end
      end
      flush_file(sc == SC_ZERO_CHANNELS || $urandom_range(0, 9) == 0);
   endtask

   // sampling and prediction at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            parse_byte(req_if.byte_in, req_if.end_of_file);
            byte_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) check_result();
      end
   end

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || byte_taken) begin
         byte_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_bytes.size() > 0 &&
                      !(pending_bytes[0].hold && expected_results.size() > 0)) begin
            next_byte = pending_bytes.pop_front();
            req_if.valid <= 1'b1;
            req_if.byte_in <= next_byte.data;
            req_if.end_of_file <= next_byte.eof;
            send_gap = pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result sink back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (calm_left > 0) calm_left--;
         else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(100, 400);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 12) stall_left = pick_gap();
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.byte_in = '0;
      req_if.end_of_file = 1'b0;
      rsp_if.ready = 1'b0;
      clear_parser();

      // lone end of file byte
      file_bytes.insert(file_bytes.size(), rand_byte());
      flush_file(1'b0);
      // broken riff tag, then a halted byte carrying end of file
      put_le(TAG_RIFF ^ 32'h1E00_0000, 4);
      file_bytes.insert(file_bytes.size(), rand_byte());
      flush_file(1'b0);
      // broken wave tag with end of file on its fourth byte
      put_le(TAG_RIFF, 4);
      put_le(32'hFFFF_FFFF, 4);
      put_le(TAG_WAVE ^ 32'h0100_0000, 4);
      flush_file(1'b0);
      // cut off inside the riff size
      put_le(TAG_RIFF, 4);
      put_le(32'h0000_0000, 2);
      flush_file(1'b0);

      build_wave_file(SC_ZERO_CHANNELS);
      build_wave_file(SC_EMPTY_DATA);
      build_wave_file(SC_TRAILING);
      build_wave_file(SC_TRUNCATED);
      build_wave_file(SC_BAD_PCM);
      build_wave_file(SC_BAD_DEPTH);
      build_wave_file(SC_BAD_FMT_SIZE);
      while (pending_bytes.size() < BYTE_TARGET) build_wave_file(SC_RANDOM);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_bytes.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

@@ wav_pcm16_stream_parser_top.f @@
sv/wpp_pkg.sv
sv/wpp_req_if.sv
sv/wpp_rsp_if.sv
sv/wpp_parser.sv
sv/wpp_result_fifo.sv
sv/wav_pcm16_stream_parser_top.sv
tb/testbench.sv
